// File: hw/rtl/amu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amu_pkg
// Shared types and constants of the atomic memory unit: memory geometry,
// atomic operation codes, exception codes and controller states.
// ----------------------------------------------------------------------------
package amu_pkg;

    // Memory geometry
    localparam int unsigned MEM_WORDS = 16384;
    localparam int unsigned IDX_W     = $clog2(MEM_WORDS);
    localparam logic [32:0] MEM_BYTES = 33'(MEM_WORDS) * 33'd4;

    // Atomic operation codes (funct5)
    typedef enum logic [4:0] {
        OP_ADD  = 5'h00,
        OP_SWAP = 5'h01,
        OP_LR   = 5'h02,
        OP_SC   = 5'h03,
        OP_XOR  = 5'h04,
        OP_OR   = 5'h08,
        OP_AND  = 5'h0c,
        OP_MIN  = 5'h10,
        OP_MAX  = 5'h14,
        OP_MINU = 5'h18,
        OP_MAXU = 5'h1c
    } amo_op_t;

    // Command kinds
    localparam logic CMD_ATOMIC = 1'b0;
    localparam logic CMD_STORE  = 1'b1;

    // Exception codes
    localparam logic [2:0] EXC_NONE           = 3'd0;
    localparam logic [2:0] EXC_LOAD_MISALIGNED = 3'd1;
    localparam logic [2:0] EXC_LOAD_FAULT     = 3'd2;
    localparam logic [2:0] EXC_AMO_MISALIGNED = 3'd3;
    localparam logic [2:0] EXC_AMO_FAULT      = 3'd4;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_STORE2
    } amu_state_t;

    // One write request to the data memory
    typedef struct packed {
        logic             wr;
        logic [3:0]       be;
        logic [IDX_W-1:0] idx;
        logic [31:0]      data;
    } mem_req_t;

endpackage

`default_nettype wire

// File: hw/rtl/atomic_memory_unit_with_reservation.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atomic_memory_unit_with_reservation
// RV32A-style atomic unit on a little-endian word memory with a one-word
// LR/SC reservation, plus a plain byte/half/word store command.
//
//   channel | dir | tdata fields (low bit up)                        | tuser
//   s_      | in  | funct5, address, operand, width (72 bits)         | cmd
//   m_      | out | load_result, exception_code, fault_address,       | -
//           |     | illegal_op, zero pad (72 bits)                    |
//
// An atomic reads memory at accept, then modifies and writes back
// through the single RAM port. A plain store that crosses a word
// boundary needs one extra write for the second word.
// The next word is accepted once the unit is back in idle, even while the
// previous result still waits on m_tready; a full output register stalls
// the write-back cycle. aresetn clears the controller, the reservation and
// the output valid; memory contents are undefined until written.
// ----------------------------------------------------------------------------
module atomic_memory_unit_with_reservation
    import amu_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // funct5[4:0], address[36:5], operand[68:37], width[71:69]
    input  wire logic [71:0] s_tdata,
    // cmd[0]
    input  wire logic        s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // load_result[31:0], exception_code[34:32], fault_address[66:35],
    // illegal_op[67], zero[71:68]
    output logic      [71:0] m_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready
);

    amu_state_t state_reg, state_next;

    // Captured item
    logic        cmd_reg;
    logic [4:0]  f_reg;
    logic [31:0] addr_reg;
    logic [31:0] opd_reg;
    logic [2:0]  w_reg;

    // Reservation
    logic        rsv_valid_reg, rsv_valid_next;
    logic [31:0] rsv_addr_reg, rsv_addr_next;

    // Output register
    logic        m_tvalid_reg, m_tvalid_next;
    logic [71:0] m_tdata_reg, m_tdata_next;

    logic        accept;
    logic        out_free;
    logic [31:0] rd_word;
    logic [31:0] alu_word;
    mem_req_t    wreq;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] idx0;

    // Decode of the captured item
    logic        op_ok;
    logic        is_lr;
    logic        misal;
    logic        afault;
    logic        rsv_hit;
    logic [3:0]  wmask;
    logic        w_ok;
    logic        st_ok;
    logic        st_ovl;
    logic [63:0] st_data;
    logic [7:0]  st_be;
    logic [32:0] addr33;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign addr33  = {1'b0, addr_reg};
    assign op_ok   = f_reg inside {OP_ADD, OP_SWAP, OP_LR, OP_SC, OP_XOR, OP_OR,
                                   OP_AND, OP_MIN, OP_MAX, OP_MINU, OP_MAXU};
    assign is_lr   = (f_reg == OP_LR);
    assign misal   = (addr_reg[1:0] != 2'b00);
    assign afault  = (addr33 + 33'd4) > MEM_BYTES;
    assign rsv_hit = rsv_valid_reg && (rsv_addr_reg == addr_reg);

    // Plain store: byte mask, range and lane alignment over two words
    always_comb begin
        case (w_reg)
            3'd1:    wmask = 4'b0001;
            3'd2:    wmask = 4'b0011;
            3'd4:    wmask = 4'b1111;
            default: wmask = 4'b0000;
        endcase
    end
    assign w_ok    = (wmask != 4'b0000);
    assign st_ok   = w_ok && ((addr33 + 33'(w_reg)) <= MEM_BYTES);
    assign st_data = {32'd0, opd_reg} << {addr_reg[1:0], 3'b000};
    assign st_be   = {4'd0, wmask} << addr_reg[1:0];
    assign st_ovl  = rsv_valid_reg
                  && ({1'b0, rsv_addr_reg} < (addr33 + 33'(w_reg)))
                  && (addr33 < ({1'b0, rsv_addr_reg} + 33'd4));

    assign rd_idx = s_tdata[IDX_W+6:7];
    assign idx0   = addr_reg[IDX_W+1:2];

    // Capture the item at accept
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg  <= s_tuser;
            f_reg    <= s_tdata[4:0];
            addr_reg <= s_tdata[36:5];
            opd_reg  <= s_tdata[68:37];
            w_reg    <= s_tdata[71:69];
        end
    end

    // Control and reservation registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rsv_valid_reg <= 1'b0;
            rsv_addr_reg  <= 32'd0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rsv_valid_reg <= rsv_valid_next;
            rsv_addr_reg  <= rsv_addr_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    // Next state, write-back and result
    always_comb begin
        logic [31:0] res;
        logic [2:0]  exc;
        logic [31:0] tval;
        logic        ill;

        res  = 32'd0;
        exc  = EXC_NONE;
        tval = 32'd0;
        ill  = 1'b0;

        state_next     = state_reg;
        rsv_valid_next = rsv_valid_reg;
        rsv_addr_next  = rsv_addr_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        wreq.wr        = 1'b0;
        wreq.be        = 4'hF;
        wreq.idx       = idx0;
        wreq.data      = alu_word;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                    if (cmd_reg == CMD_STORE) begin
                        if (st_ok) begin
                            wreq.wr   = 1'b1;
                            wreq.be   = st_be[3:0];
                            wreq.data = st_data[31:0];
                            if (st_ovl) begin
                                rsv_valid_next = 1'b0;
                            end
                            if (st_be[7:4] != 4'd0) begin
                                state_next = ST_STORE2;
                            end
                        end
                    end else if (!op_ok) begin
                        ill = 1'b1;
                    end else if (misal) begin
                        exc  = is_lr ? EXC_LOAD_MISALIGNED : EXC_AMO_MISALIGNED;
                        tval = addr_reg;
                    end else if (afault) begin
                        exc  = is_lr ? EXC_LOAD_FAULT : EXC_AMO_FAULT;
                        tval = addr_reg;
                    end else if (f_reg == OP_SC) begin
                        rsv_valid_next = 1'b0;
                        res            = rsv_hit ? 32'd0 : 32'd1;
                        wreq.wr        = rsv_hit;
                        wreq.data      = opd_reg;
                    end else if (is_lr) begin
                        res            = rd_word;
                        rsv_addr_next  = addr_reg;
                        rsv_valid_next = 1'b1;
                    end else begin
                        res     = rd_word;
                        wreq.wr = 1'b1;
                        if (rsv_hit) begin
                            rsv_valid_next = 1'b0;
                        end
                    end
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'd0, ill, tval, exc, res};
                end
            end
            ST_STORE2: begin
                // Upper bytes of a store that crosses into the next word
                wreq.wr    = 1'b1;
                wreq.be    = st_be[7:4];
                wreq.idx   = idx0 + IDX_W'(1);
                wreq.data  = st_data[63:32];
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    amu_alu u_alu (
        .funct5   (f_reg),
        .old_word (rd_word),
        .operand  (opd_reg),
        .new_word (alu_word)
    );

    amu_ram #(
        .WORDS  (MEM_WORDS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (accept),
        .wr_en   (wreq.wr),
        .wr_be   (wreq.be),
        .addr    (accept ? rd_idx : wreq.idx),
        .wr_data (wreq.data),
        .rd_data (rd_word)
    );

endmodule

`default_nettype wire

// File: hw/rtl/amu_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amu_ram
// Single-port synchronous word RAM with byte write enables and a
// registered read.
// ----------------------------------------------------------------------------
module amu_ram #(
    parameter int unsigned WORDS  = 16384,
    parameter int unsigned ADDR_W = $clog2(WORDS)
) (
    input  wire logic              aclk,
    input  wire logic              rd_en,
    input  wire logic              wr_en,
    input  wire logic [3:0]        wr_be,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [31:0]       wr_data,
    output logic      [31:0]       rd_data
);

    logic [31:0] mem [WORDS];
    logic [31:0] rd_data_reg;

    // Byte-masked write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            for (int b = 0; b < 4; b++) begin
                if (wr_be[b]) begin
                    mem[addr][8*b +: 8] <= wr_data[8*b +: 8];
                end
            end
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/amu_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amu_alu
// Combines the old memory word with the operand for the read-modify-write
// atomics (add, swap, logic ops, signed and unsigned min/max).
// ----------------------------------------------------------------------------
module amu_alu
    import amu_pkg::*;
(
    input  wire logic [4:0]  funct5,
    input  wire logic [31:0] old_word,
    input  wire logic [31:0] operand,
    output logic      [31:0] new_word
);

    logic slt;
    logic ult;

    assign slt = $signed(old_word) < $signed(operand);
    assign ult = old_word < operand;

    always_comb begin
        case (amo_op_t'(funct5))
            OP_ADD:  new_word = old_word + operand;
            OP_SWAP: new_word = operand;
            OP_XOR:  new_word = old_word ^ operand;
            OP_OR:   new_word = old_word | operand;
            OP_AND:  new_word = old_word & operand;
            OP_MIN:  new_word = slt ? old_word : operand;
            OP_MAX:  new_word = slt ? operand : old_word;
            OP_MINU: new_word = ult ? old_word : operand;
            OP_MAXU: new_word = ult ? operand : old_word;
            default: new_word = old_word;
        endcase
    end

endmodule

`default_nettype wire

// File: bench/tb_atomic_memory_unit_with_reservation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_atomic_memory_unit_with_reservation
// Self-checking bench for the atomic memory unit. A table of directed words
// covers plain stores, LR/SC pairs, every AMO, illegal codes and both kinds
// of address exception; random words follow, mostly LR/SC and AMO traffic on
// a small pool of initialized memory words. Every result word is checked
// field by field against a shadow copy of the memory and the reservation.
// ----------------------------------------------------------------------------
module tb_atomic_memory_unit_with_reservation
    import amu_pkg::*;
();

    localparam int          TOTAL_ITEMS    = 450;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          HOLD_CYCLES    = 80;
    localparam int          DRAIN_CYCLES   = 20;
    localparam logic [31:0] END_ADDR       = 32'(MEM_BYTES);
    localparam logic [31:0] LAST_WORD      = END_ADDR - 32'd4;

    // one result word, split into its fields
    typedef struct packed {
        logic [31:0] load_result;
        logic [2:0]  exc;
        logic [31:0] fault;
        logic        ill;
    } amo_result_t;

    // one row of the directed table
    typedef struct packed {
        logic        cmd;
        logic [4:0]  f5;
        logic [31:0] addr;
        logic [31:0] opd;
        logic [2:0]  w;
        logic        typed;
        amo_result_t want;
    } stim_row_t;

    localparam amo_result_t ZERO_RES = '0;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic [71:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;

    // shadow of the block's state
    logic [31:0] shadow_mem   [MEM_WORDS];
    bit   [3:0]  shadow_known [MEM_WORDS];
    logic [31:0] resv_addr  = '0;
    bit          resv_valid = 1'b0;

    amo_result_t pending_results[$];
    stim_row_t   dir_tab[$];
    int          region_idx[$];
    amo_op_t     op_list[11] = '{OP_ADD, OP_SWAP, OP_XOR, OP_OR, OP_AND, OP_MIN,
                                 OP_MAX, OP_MINU, OP_MAXU, OP_LR, OP_SC};

    int accepted      = 0;
    int results_seen  = 0;
    int err_count     = 0;
    int stall_cycles  = 0;
    int send_idle_pct = 24;
    int recv_idle_pct = 50;
    bit hold_req      = 1'b0;
    bit pressure_done = 1'b0;

    atomic_memory_unit_with_reservation uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic bit op_known(input logic [4:0] f5);
        case (f5)
            OP_ADD, OP_SWAP, OP_LR, OP_SC, OP_XOR, OP_OR, OP_AND,
            OP_MIN, OP_MAX, OP_MINU, OP_MAXU: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // any write touching the reserved word kills the reservation
    function automatic void clear_overlap(input logic [31:0] a, input int unsigned n);
        if (resv_valid && {1'b0, a} < {1'b0, resv_addr} + 33'd4 &&
            {1'b0, resv_addr} < {1'b0, a} + 33'(n))
            resv_valid = 1'b0;
    endfunction

    // expected result of one word; updates the shadow state
    function automatic amo_result_t amo_outcome(input logic cmd, input logic [4:0] f5,
                                                input logic [31:0] addr,
                                                input logic [31:0] opd,
                                                input logic [2:0] w);
        amo_result_t r;
        logic [31:0] b;
        logic [31:0] old;
        logic [31:0] nv;
        bit          ok;
        int unsigned idx;
        r   = ZERO_RES;
        idx = addr[IDX_W+1:2];
        if (cmd == CMD_STORE) begin
            if ((w == 3'd1 || w == 3'd2 || w == 3'd4) &&
                {1'b0, addr} + 33'(w) <= MEM_BYTES) begin
                for (int j = 0; j < w; j++) begin
                    b = addr + 32'(j);
                    shadow_mem[b[IDX_W+1:2]][8*b[1:0] +: 8] = opd[8*j +: 8];
                    shadow_known[b[IDX_W+1:2]][b[1:0]] = 1'b1;
                end
                clear_overlap(addr, w);
            end
        end else if (!op_known(f5)) begin
            r.ill = 1'b1;
        end else if (addr[1:0] != 2'b00) begin
            r.exc   = (f5 == OP_LR) ? EXC_LOAD_MISALIGNED : EXC_AMO_MISALIGNED;
            r.fault = addr;
        end else if ({1'b0, addr} + 33'd4 > MEM_BYTES) begin
            r.exc   = (f5 == OP_LR) ? EXC_LOAD_FAULT : EXC_AMO_FAULT;
            r.fault = addr;
        end else if (f5 == OP_SC) begin
            ok            = resv_valid && resv_addr == addr;
            resv_valid    = 1'b0;
            r.load_result = ok ? 32'd0 : 32'd1;
            if (ok) begin
                shadow_mem[idx]   = opd;
                shadow_known[idx] = 4'hF;
            end
        end else if (f5 == OP_LR) begin
            r.load_result = shadow_mem[idx];
            resv_addr     = addr;
            resv_valid    = 1'b1;
        end else begin
            old = shadow_mem[idx];
            case (f5)
                OP_ADD:  nv = old + opd;
                OP_SWAP: nv = opd;
                OP_XOR:  nv = old ^ opd;
                OP_OR:   nv = old | opd;
                OP_AND:  nv = old & opd;
                OP_MIN:  nv = ($signed(old) < $signed(opd)) ? old : opd;
                OP_MAX:  nv = ($signed(old) < $signed(opd)) ? opd : old;
                OP_MINU: nv = (old < opd) ? old : opd;
                default: nv = (old < opd) ? opd : old;
            endcase
            r.load_result   = old;
            shadow_mem[idx] = nv;
            clear_overlap(addr, 4);
        end
        return r;
    endfunction

    function automatic stim_row_t row(input logic cmd, input logic [4:0] f5,
                                      input logic [31:0] addr, input logic [31:0] opd,
                                      input logic [2:0] w, input logic typed,
                                      input amo_result_t want);
        stim_row_t t;
        t = '{cmd, f5, addr, opd, w, typed, want};
        return t;
    endfunction

    // random word of the pool whose four bytes are all written, or -1
    function automatic int pick_known_word();
        int cand[$];
        foreach (region_idx[i])
            if (shadow_known[region_idx[i]] == 4'hF)
                cand.push_back(region_idx[i]);
        if (cand.size() == 0)
            return -1;
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch in result %0d, %s: got %h want %h", results_seen, what, got,
                 want);
        err_count++;
    endtask

    // offer one input word and record its expected result at acceptance
    task automatic push_word(input logic cmd, input logic [4:0] f5,
                             input logic [31:0] addr, input logic [31:0] opd,
                             input logic [2:0] w, input logic typed,
                             input amo_result_t fixed);
        amo_result_t want;
        if (accepted < 150) begin
            send_idle_pct = 24;
            recv_idle_pct = 50;
        end else if (accepted < 300) begin
            send_idle_pct = 50;
            recv_idle_pct = 24;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            if (!pressure_done) begin
                hold_req      = 1'b1;
                pressure_done = 1'b1;
            end
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {w, opd, addr, f5};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        want = amo_outcome(cmd, f5, addr, opd, w);
        pending_results.push_back(typed ? fixed : want);
        accepted++;
    endtask

    // receiver: random back-pressure, plus one long hold-off
    initial begin : rx_drive
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                for (int h = 0; h < HOLD_CYCLES; h++) begin
                    m_tready <= 1'b0;
                    @(posedge aclk);
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // result checker
    always @(posedge aclk) begin
        amo_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", m_tdata[31:0], 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[31:0] !== want.load_result)
                    report_mismatch("load_result", m_tdata[31:0], want.load_result);
                if (m_tdata[34:32] !== want.exc)
                    report_mismatch("exception_code", 32'(m_tdata[34:32]), 32'(want.exc));
                if (m_tdata[66:35] !== want.fault)
                    report_mismatch("fault_address", m_tdata[66:35], want.fault);
                if (m_tdata[67] !== want.ill)
                    report_mismatch("illegal_op", 32'(m_tdata[67]), 32'(want.ill));
            end
            results_seen++;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        amo_result_t fx;
        logic        cmd;
        logic [4:0]  f5;
        logic [31:0] addr;
        logic [31:0] opd;
        logic [2:0]  w;
        logic [31:0] lr_addr;
        bit          sc_due;
        int          k;
        int          pick;
        sc_due  = 1'b0;
        lr_addr = '0;
        for (int i = 0; i < 32; i++)
            region_idx.push_back(i);
        for (int i = MEM_WORDS - 4; i < MEM_WORDS; i++)
            region_idx.push_back(i);

        // directed table: fill a few words, then LR/SC, AMOs and faults
        dir_tab.push_back(row(CMD_STORE, OP_ADD, 32'h0, 32'hFFFF_FFFF, 3'd4, 1'b1, ZERO_RES));
        dir_tab.push_back(row(CMD_STORE, OP_ADD, 32'h4, 32'h8000_0000, 3'd4, 1'b0, ZERO_RES));
        dir_tab.push_back(row(CMD_STORE, OP_ADD, LAST_WORD, 32'h7FFF_FFFF, 3'd4, 1'b0,
                              ZERO_RES));
        // store running past the end of memory: dropped
        dir_tab.push_back(row(CMD_STORE, OP_ADD, END_ADDR - 32'd2, 32'h1234_5678, 3'd4,
                              1'b1, ZERO_RES));
        // bad byte count: dropped
        dir_tab.push_back(row(CMD_STORE, OP_ADD, 32'h0, 32'h0, 3'd7, 1'b1, ZERO_RES));
        // word store straddling words 2 and 3, then the missing halves
        dir_tab.push_back(row(CMD_STORE, OP_ADD, 32'hA, 32'hA1B2_C3D4, 3'd4, 1'b0, ZERO_RES));
        dir_tab.push_back(row(CMD_STORE, OP_ADD, 32'h8, 32'h0000_5566, 3'd2, 1'b0, ZERO_RES));
        dir_tab.push_back(row(CMD_STORE, OP_ADD, 32'hE, 32'h0000_7788, 3'd2, 1'b0, ZERO_RES));
        // byte store into the reserved word breaks the reservation
        dir_tab.push_back(row(CMD_ATOMIC, OP_LR, 32'h0, 32'h0, 3'd0, 1'b0, ZERO_RES));
        dir_tab.push_back(row(CMD_STORE, OP_ADD, 32'h3, 32'h0000_0000, 3'd1, 1'b0, ZERO_RES));
        dir_tab.push_back(row(CMD_ATOMIC, OP_SC, 32'h0, 32'h5555_5555, 3'd0, 1'b0, ZERO_RES));
        dir_tab.push_back(row(CMD_ATOMIC, OP_LR, 32'h4, 32'h0, 3'd0, 1'b0, ZERO_RES));
        dir_tab.push_back(row(CMD_ATOMIC, OP_SC, 32'h4, 32'h0000_0001, 3'd0, 1'b0, ZERO_RES));
        // a faulting SC leaves the reservation alone
        dir_tab.push_back(row(CMD_ATOMIC, OP_LR, 32'h8, 32'h0, 3'd0, 1'b0, ZERO_RES));
        fx = '{32'h0, EXC_AMO_MISALIGNED, 32'h1, 1'b0};
        dir_tab.push_back(row(CMD_ATOMIC, OP_SC, 32'h1, 32'h0, 3'd0, 1'b1, fx));
        dir_tab.push_back(row(CMD_ATOMIC, OP_SC, 32'h8, 32'hCAFE_F00D, 3'd0, 1'b0, ZERO_RES));
        // every read-modify-write operation
        dir_tab.push_back(row(CMD_ATOMIC, OP_ADD, LAST_WORD, 32'hFFFF_FFFF, 3'd0, 1'b0,
                              ZERO_RES));
        dir_tab.push_back(row(CMD_ATOMIC, OP_SWAP, 32'h0, 32'h8000_0000, 3'd0, 1'b0, ZERO_RES));
        dir_tab.push_back(row(CMD_ATOMIC, OP_XOR, 32'h4, 32'hFFFF_FFFF, 3'd0, 1'b0, ZERO_RES));
        dir_tab.push_back(row(CMD_ATOMIC, OP_OR, 32'h8, 32'h0F0F_0F0F, 3'd0, 1'b0, ZERO_RES));
        dir_tab.push_back(row(CMD_ATOMIC, OP_AND, 32'hC, 32'hF0F0_F0F0, 3'd0, 1'b0, ZERO_RES));
        dir_tab.push_back(row(CMD_ATOMIC, OP_MIN, 32'h0, 32'h7FFF_FFFF, 3'd0, 1'b0, ZERO_RES));
        dir_tab.push_back(row(CMD_ATOMIC, OP_MAX, 32'h4, 32'h8000_0000, 3'd0, 1'b0, ZERO_RES));
        dir_tab.push_back(row(CMD_ATOMIC, OP_MINU, 32'h8, 32'h0, 3'd0, 1'b0, ZERO_RES));
        dir_tab.push_back(row(CMD_ATOMIC, OP_MAXU, 32'hC, 32'hFFFF_FFFF, 3'd0, 1'b0,
                              ZERO_RES));
        // illegal code and the load misaligned, load fault and AMO fault exceptions
        fx = '{32'h0, EXC_NONE, 32'h0, 1'b1};
        dir_tab.push_back(row(CMD_ATOMIC, 5'h1F, 32'h0, 32'hFFFF_FFFF, 3'd0, 1'b1, fx));
        fx = '{32'h0, EXC_LOAD_MISALIGNED, 32'hFFFF_FFFF, 1'b0};
        dir_tab.push_back(row(CMD_ATOMIC, OP_LR, 32'hFFFF_FFFF, 32'h0, 3'd0, 1'b1, fx));
        fx = '{32'h0, EXC_LOAD_FAULT, END_ADDR, 1'b0};
        dir_tab.push_back(row(CMD_ATOMIC, OP_LR, END_ADDR, 32'h0, 3'd0, 1'b1, fx));
        fx = '{32'h0, EXC_AMO_FAULT, 32'hFFFF_FFFC, 1'b0};
        dir_tab.push_back(row(CMD_ATOMIC, OP_SC, 32'hFFFF_FFFC, 32'h0, 3'd0, 1'b1, fx));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i])
            push_word(dir_tab[i].cmd, dir_tab[i].f5, dir_tab[i].addr, dir_tab[i].opd,
                      dir_tab[i].w, dir_tab[i].typed, dir_tab[i].want);

        // random traffic
        while (accepted < TOTAL_ITEMS) begin
            cmd  = CMD_ATOMIC;
            f5   = 5'($urandom);
            opd  = $urandom;
            w    = 3'($urandom);
            pick = $urandom_range(0, 99);
            k    = pick_known_word();
            case ($urandom_range(0, 7))
                0:       opd = 32'h0;
                1:       opd = 32'hFFFF_FFFF;
                2:       opd = 32'h8000_0000;
                3:       opd = 32'h7FFF_FFFF;
                default: ;
            endcase
            if (sc_due && k >= 0) begin
                // SC following an LR, mostly to the reserved word
                sc_due = 1'b0;
                f5     = OP_SC;
                addr   = ($urandom_range(0, 4) != 0) ? lr_addr : 32'(k) << 2;
            end else if (pick < 30 || k < 0) begin
                // plain store of any size and alignment
                cmd = CMD_STORE;
                if ($urandom_range(0, 9) != 0)
                    w = 3'(1 << $urandom_range(0, 2));
                case ($urandom_range(0, 9))
                    0:       addr = $urandom;
                    1:       addr = END_ADDR - 32'($urandom_range(0, 6));
                    default: addr = (32'(region_idx[$urandom_range(0, region_idx.size() - 1)])
                                     << 2) + 32'($urandom_range(0, 3));
                endcase
            end else if (pick < 40) begin
                // undefined operation code
                do
                    f5 = 5'($urandom);
                while (op_known(f5));
                addr = $urandom_range(0, 1) ? $urandom : (32'(k) << 2) + 32'($urandom_range(0, 3));
            end else if (pick < 50) begin
                // misaligned or out-of-range atomic
                f5 = op_list[$urandom_range(0, 10)];
                case ($urandom_range(0, 2))
                    0: addr = (32'(k) << 2) + 32'($urandom_range(1, 3));
                    1: begin
                        addr = $urandom;
                        if (addr[1:0] == 2'b00 && {1'b0, addr} + 33'd4 <= MEM_BYTES)
                            addr[31] = 1'b1;
                    end
                    default: addr = $urandom_range(0, 1) ? 32'hFFFF_FFFC :
                                    END_ADDR + 32'(4 * $urandom_range(0, 3));
                endcase
            end else begin
                // well-formed LR, SC or AMO on an initialized word
                addr = 32'(k) << 2;
                if ($urandom_range(0, 9) < 3) begin
                    f5      = OP_LR;
                    lr_addr = addr;
                    sc_due  = ($urandom_range(0, 9) < 6);
                end else if ($urandom_range(0, 9) < 2) begin
                    f5 = OP_SC;
                end else begin
                    f5 = op_list[$urandom_range(0, 8)];
                end
            end
            push_word(cmd, f5, addr, opd, w, 1'b0, ZERO_RES);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0)
            report_mismatch("missing results", 32'(pending_results.size()), 32'd0);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
